>>> design/scmrf_pkg.sv
package scmrf_pkg;

  localparam int unsigned SNP_TABLE_DEPTH = 65536;
  localparam int unsigned ADDR_W = $clog2(SNP_TABLE_DEPTH);
  localparam int unsigned CNT_W = ADDR_W + 1;

  localparam int unsigned POS_W = 31;
  localparam int unsigned QUAL_W = 8;
  localparam int unsigned RATIO_W = 17;
  localparam int unsigned TALLY_W = 17;
  localparam int unsigned PROD_W = RATIO_W + TALLY_W;
  localparam int unsigned FRAC_W = 16;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_APPEND   = 3'd1;
  localparam logic [2:0] OP_START    = 3'd2;
  localparam logic [2:0] OP_MISMATCH = 3'd3;
  localparam logic [2:0] OP_END      = 3'd4;

  localparam logic [1:0] REG_CLUSTER_MARGIN   = 2'd0;
  localparam logic [1:0] REG_RATIO_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_MIN_BASE_QUALITY = 2'd2;

  localparam logic [POS_W-1:0]   RESET_CLUSTER_MARGIN   = POS_W'(1000);
  localparam logic [RATIO_W-1:0] RESET_RATIO_THRESHOLD  = RATIO_W'(19661);
  localparam logic [QUAL_W-1:0]  RESET_MIN_BASE_QUALITY = QUAL_W'(10);

  typedef struct packed {
    logic [2:0]        opcode;
    logic [POS_W-1:0]  position;
    logic [QUAL_W-1:0] base_quality;
  } item_t;

  typedef struct packed {
    logic               keep_read;
    logic               bypassed;
    logic [TALLY_W-1:0] mismatch_count;
    logic [TALLY_W-1:0] cluster_total;
    logic               table_overflowed;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [TALLY_W-1:0] mismatches;
    logic [TALLY_W-1:0] snps;
  } ratio_req_t;

  typedef struct packed {
    logic valid;
    logic reached;
  } ratio_rsp_t;

  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
    return (v == TALLY_MAX) ? v : v + TALLY_W'(1);
  endfunction

endpackage

>>> design/scmrf_cluster_mismatch_read_filter_core.sv
// SNP cluster mismatch read filter for one contig.
// Items arrive on the item channel (item_valid, item_stall, item) and are
// taken at an edge where item_valid is high and item_stall is low. Results
// leave on the result channel (result_valid, result_stall, result); one
// result is produced for each read end item that closes an open read.
// The block works on one item at a time and holds item_stall high until the
// item is done. Clear, append and ignored items need no further state. A
// read start with no table entry left is bypassed without a table read; else
// it steps the start index, each step reading the single table read port. A
// mismatch walks the table one SNP at a time, and each time a cluster closes
// it passes the cluster through the shared two-stage ratio multiplier; it
// ends right after the ratio check when that check filters the read. A read
// end that is not bypassed passes the ratio check before its result is
// registered. The result register frees the input side: a stalled result is
// held unchanged while the next items are processed, and only a following
// read end waits for it to be taken. Synchronous reset empties the table,
// closes any open read and restores the register defaults; no clearing pass
// over the table is needed. The user writes configuration over the APB port
// only while the block is idle; the block itself does not enforce this.
module snp_cluster_mismatch_read_filter_core
  import scmrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RB_READ,
    ST_RB_CHECK,
    ST_MM_CHECK,
    ST_MM_STEP,
    ST_MM_RATIO,
    ST_END_RATIO,
    ST_END_OUT
  } state_t;

  state_t state;

  logic [POS_W-1:0]   cluster_margin;
  logic [RATIO_W-1:0] ratio_threshold;
  logic [QUAL_W-1:0]  min_base_quality;

  logic [CNT_W-1:0]   snp_count;
  logic [ADDR_W-1:0]  start_index;
  logic [ADDR_W-1:0]  walk_index;
  logic [POS_W-1:0]   current_snp;
  logic [TALLY_W-1:0] cluster_mismatches;
  logic [TALLY_W-1:0] cluster_snps;
  logic               read_filtered;
  logic               read_bypass;
  logic               overflow_flag;
  logic               read_open;
  logic               pend_keep;
  logic [POS_W-1:0]   cur_pos;
  logic [QUAL_W-1:0]  cur_qual;

  logic               accept;
  logic               cfg_write;
  logic               tbl_wr_en;
  logic [ADDR_W-1:0]  tbl_rd_addr;
  logic [POS_W-1:0]   tbl_rd_data;
  logic               gap;
  logic               out_free;
  ratio_req_t         ratio_req;
  ratio_rsp_t         ratio_rsp;

  assign accept = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free = !result_valid || !result_stall;

  assign tbl_wr_en = accept && (item.opcode == OP_APPEND) &&
                     (snp_count < CNT_W'(SNP_TABLE_DEPTH));

  always_comb begin
    unique case (state)
      ST_RB_READ:  tbl_rd_addr = start_index;
      ST_RB_CHECK: tbl_rd_addr = start_index + ADDR_W'(1);
      default:     tbl_rd_addr = walk_index + ADDR_W'(1);
    endcase
  end

  // A gap wider than the margin between the previous SNP and the new one
  // closes the current cluster.
  assign gap = ({1'b0, current_snp} + {1'b0, cluster_margin}) < {1'b0, tbl_rd_data};

  always_comb begin
    ratio_req.mismatches = cluster_mismatches;
    ratio_req.snps = cluster_snps;
    ratio_req.valid = ((state == ST_MM_STEP) && gap && (cluster_snps != '0)) ||
                      (accept && (item.opcode == OP_END) && read_open && !read_bypass);
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CLUSTER_MARGIN:   prdata = PDATA_W'(cluster_margin);
      REG_RATIO_THRESHOLD:  prdata = PDATA_W'(ratio_threshold);
      REG_MIN_BASE_QUALITY: prdata = PDATA_W'(min_base_quality);
      default:              prdata = '0;
    endcase
  end

  scmrf_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (snp_count[ADDR_W-1:0]),
    .wr_data (item.position),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  scmrf_ratio u_ratio (
    .clk       (clk),
    .rst       (rst),
    .threshold (ratio_threshold),
    .req       (ratio_req),
    .rsp       (ratio_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_margin <= RESET_CLUSTER_MARGIN;
      ratio_threshold <= RESET_RATIO_THRESHOLD;
      min_base_quality <= RESET_MIN_BASE_QUALITY;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_CLUSTER_MARGIN:   cluster_margin <= pwdata[POS_W-1:0];
        REG_RATIO_THRESHOLD:  ratio_threshold <= pwdata[RATIO_W-1:0];
        REG_MIN_BASE_QUALITY: min_base_quality <= pwdata[QUAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      snp_count <= '0;
      start_index <= '0;
      walk_index <= '0;
      cluster_mismatches <= '0;
      cluster_snps <= '0;
      read_filtered <= 1'b0;
      read_bypass <= 1'b0;
      overflow_flag <= 1'b0;
      read_open <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != ST_END_OUT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_pos <= item.position;
            cur_qual <= item.base_quality;
            unique case (item.opcode)
              OP_CLEAR: begin
                snp_count <= '0;
                start_index <= '0;
                overflow_flag <= 1'b0;
                read_open <= 1'b0;
              end
              OP_APPEND: begin
                if (tbl_wr_en) begin
                  snp_count <= snp_count + CNT_W'(1);
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              OP_START: begin
                read_open <= 1'b1;
                read_filtered <= 1'b0;
                cluster_mismatches <= '0;
                cluster_snps <= '0;
                if ({1'b0, start_index} >= snp_count) begin
                  read_bypass <= 1'b1;
                end else begin
                  read_bypass <= 1'b0;
                  state <= ST_RB_READ;
                end
              end
              OP_MISMATCH: begin
                if (read_open && !read_bypass && !read_filtered) begin
                  state <= ST_MM_CHECK;
                end
              end
              OP_END: begin
                if (read_open) begin
                  read_open <= 1'b0;
                  if (read_bypass) begin
                    pend_keep <= 1'b1;
                    state <= ST_END_OUT;
                  end else begin
                    state <= ST_END_RATIO;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_RB_READ: begin
          state <= ST_RB_CHECK;
        end
        ST_RB_CHECK: begin
          current_snp <= tbl_rd_data;
          if (tbl_rd_data < cur_pos) begin
            if (({1'b0, start_index} + CNT_W'(1)) < snp_count) begin
              start_index <= start_index + ADDR_W'(1);
            end else begin
              read_bypass <= 1'b1;
              state <= ST_IDLE;
            end
          end else begin
            walk_index <= start_index;
            cluster_snps <= TALLY_W'(1);
            state <= ST_IDLE;
          end
        end
        ST_MM_CHECK: begin
          if ((current_snp < cur_pos) &&
              (({1'b0, walk_index} + CNT_W'(1)) < snp_count)) begin
            walk_index <= walk_index + ADDR_W'(1);
            state <= ST_MM_STEP;
          end else begin
            if ((current_snp == cur_pos) && (cur_qual >= min_base_quality)) begin
              cluster_mismatches <= sat_inc(cluster_mismatches);
            end
            state <= ST_IDLE;
          end
        end
        ST_MM_STEP: begin
          current_snp <= tbl_rd_data;
          if (ratio_req.valid) begin
            state <= ST_MM_RATIO;
          end else begin
            cluster_snps <= sat_inc(cluster_snps);
            state <= ST_MM_CHECK;
          end
        end
        ST_MM_RATIO: begin
          if (ratio_rsp.valid) begin
            if (ratio_rsp.reached) begin
              read_filtered <= 1'b1;
              state <= ST_IDLE;
            end else begin
              cluster_mismatches <= '0;
              cluster_snps <= TALLY_W'(1);
              state <= ST_MM_CHECK;
            end
          end
        end
        ST_END_RATIO: begin
          if (ratio_rsp.valid) begin
            pend_keep <= !(read_filtered || ratio_rsp.reached);
            state <= ST_END_OUT;
          end
        end
        ST_END_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_END_OUT) && out_free) begin
      result.keep_read <= pend_keep;
      result.bypassed <= read_bypass;
      result.mismatch_count <= cluster_mismatches;
      result.cluster_total <= cluster_snps;
      result.table_overflowed <= overflow_flag;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    snp_count <= CNT_W'(SNP_TABLE_DEPTH))
    else $error("table fill count beyond table depth");

  assert property (@(posedge clk) disable iff (rst)
    ratio_req.valid |-> ##2 ratio_rsp.valid)
    else $error("ratio unit did not answer two cycles after a request");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && read_open && !read_bypass |->
      (walk_index >= start_index) && ({1'b0, walk_index} < snp_count))
    else $error("walk index outside the table span of the open read");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bypassed |->
      result.keep_read && (result.mismatch_count == '0) && (result.cluster_total == '0))
    else $error("bypassed read reported with cluster counts");

endmodule

>>> design/scmrf_table.sv
module scmrf_table
  import scmrf_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [POS_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [POS_W-1:0]  rd_data
);

  logic [POS_W-1:0] mem [SNP_TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/scmrf_ratio.sv
module scmrf_ratio
  import scmrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [RATIO_W-1:0] threshold,
  input  ratio_req_t         req,
  output ratio_rsp_t         rsp
);

  logic               stage_valid;
  logic [PROD_W-1:0]  product;
  logic [TALLY_W-1:0] mismatches;
  logic               snps_zero;
  logic               threshold_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      stage_valid <= req.valid;
      rsp.valid <= stage_valid;
    end
    product <= PROD_W'(threshold) * PROD_W'(req.snps);
    mismatches <= req.mismatches;
    snps_zero <= (req.snps == '0);
    threshold_zero <= (threshold == '0);
    if (snps_zero) begin
      rsp.reached <= threshold_zero;
    end else begin
      rsp.reached <= ({1'b0, mismatches, FRAC_W'(0)} >= product);
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench
  import scmrf_pkg::*;
;

  localparam int unsigned POS_MAX = 32'h7FFF_FFFF;
  localparam int unsigned TALLY_TOP = 2**TALLY_W - 1;
  localparam int DRAIN_PAUSE = 500;

  // Predicts the keep or filter verdict of each read from the SNP table and the
  // cluster walk, and holds the verdicts that the block has yet to return.
  class verdict_scoreboard;
    bit [POS_W-1:0] snp_pos [SNP_TABLE_DEPTH];
    int unsigned snp_cnt, start_idx, walk_idx, clu_mm, clu_snps;
    bit [POS_W-1:0] cur_snp;
    longint prev_snp;
    bit filtered, bypass, overflow, read_open;
    bit [POS_W-1:0] margin;
    bit [RATIO_W-1:0] thresh;
    bit [QUAL_W-1:0] min_qual;
    result_t pending_verdicts[$];
    int errors;

    function new();
      margin = RESET_CLUSTER_MARGIN;
      thresh = RESET_RATIO_THRESHOLD;
      min_qual = RESET_MIN_BASE_QUALITY;
    endfunction

    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_CLUSTER_MARGIN: margin = val[POS_W-1:0];
        REG_RATIO_THRESHOLD: thresh = val[RATIO_W-1:0];
        REG_MIN_BASE_QUALITY: min_qual = val[QUAL_W-1:0];
        default: ;
      endcase
    endfunction

    function bit ratio_hit(int unsigned m, int unsigned t);
      if (t == 0) return thresh == 0;
      return longint'(m) * 65536 >= longint'(thresh) * longint'(t);
    endfunction

    function int unsigned bump(int unsigned v);
      return (v < TALLY_TOP) ? v + 1 : v;
    endfunction

    function void take_item(item_t it);
      result_t r;
      case (it.opcode)
        OP_CLEAR: begin
          snp_cnt = 0;
          start_idx = 0;
          overflow = 0;
          read_open = 0;
        end
        OP_APPEND: begin
          if (snp_cnt < SNP_TABLE_DEPTH) begin
            snp_pos[snp_cnt] = it.position;
            snp_cnt++;
          end else begin
            overflow = 1;
          end
        end
        OP_START: begin
          read_open = 1;
          filtered = 0;
          bypass = 0;
          clu_mm = 0;
          clu_snps = 0;
          if (snp_cnt == 0 || start_idx >= snp_cnt) begin
            bypass = 1;
            return;
          end
          cur_snp = snp_pos[start_idx];
          while (cur_snp < it.position && start_idx + 1 < snp_cnt) begin
            start_idx++;
            cur_snp = snp_pos[start_idx];
          end
          if (cur_snp < it.position) begin
            bypass = 1;
            return;
          end
          walk_idx = start_idx;
          prev_snp = -longint'(margin);
          clu_snps = 1;
        end
        OP_MISMATCH: begin
          if (!read_open || bypass || filtered) return;
          while (cur_snp < it.position && walk_idx + 1 < snp_cnt) begin
            walk_idx++;
            prev_snp = longint'(cur_snp);
            cur_snp = snp_pos[walk_idx];
            if (prev_snp + longint'(margin) < longint'(cur_snp) && clu_snps > 0) begin
              if (ratio_hit(clu_mm, clu_snps)) begin
                filtered = 1;
                return;
              end
              clu_snps = 0;
              clu_mm = 0;
            end
            clu_snps = bump(clu_snps);
          end
          if (it.position == cur_snp && it.base_quality >= min_qual) clu_mm = bump(clu_mm);
        end
        OP_END: begin
          if (!read_open) return;
          read_open = 0;
          if (bypass) begin
            r.keep_read = 1'b1;
            r.bypassed = 1'b1;
            r.mismatch_count = '0;
            r.cluster_total = '0;
          end else begin
            r.keep_read = !(filtered || ratio_hit(clu_mm, clu_snps));
            r.bypassed = 1'b0;
            r.mismatch_count = TALLY_W'(clu_mm);
            r.cluster_total = TALLY_W'(clu_snps);
          end
          r.table_overflowed = overflow;
          pending_verdicts.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no verdict pending");
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.keep_read !== want.keep_read) begin
        $error("keep_read: expected %0d, actual %0d", want.keep_read, got.keep_read);
        errors++;
      end
      if (got.bypassed !== want.bypassed) begin
        $error("bypassed: expected %0d, actual %0d", want.bypassed, got.bypassed);
        errors++;
      end
      if (got.mismatch_count !== want.mismatch_count) begin
        $error("mismatch_count: expected %0d, actual %0d",
               want.mismatch_count, got.mismatch_count);
        errors++;
      end
      if (got.cluster_total !== want.cluster_total) begin
        $error("cluster_total: expected %0d, actual %0d",
               want.cluster_total, got.cluster_total);
        errors++;
      end
      if (got.table_overflowed !== want.table_overflowed) begin
        $error("table_overflowed: expected %0d, actual %0d",
               want.table_overflowed, got.table_overflowed);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  verdict_scoreboard sb;
  bit [POS_W-1:0] loaded[$];
  int sent = 0;
  int burst_left = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;
  int rx_count = 0;
  bit held = 1'b0;

  snp_cluster_mismatch_read_filter_core u_top (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_verdict(result);
  end

  // The receiver changes its stall pattern now and then, and holds off once for a
  // long stretch so that read ends back up behind the result register.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) rx_count++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 80);
    end else begin
      mode_left--;
    end
    if (!held && rx_count >= 40) begin
      held = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= 1'($urandom_range(0, 1));
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= ~result_stall;
      endcase
    end
  end

  task automatic offer(input logic [2:0] op, input logic [POS_W-1:0] pos,
                       input logic [QUAL_W-1:0] qual);
    item_t it;
    int gap;
    it.opcode = op;
    it.position = pos;
    it.base_quality = qual;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.take_item(it);
    if (burst_left > 0) burst_left--;
    if (op <= OP_END) sent++;
    if (op == OP_CLEAR) loaded.delete();
    else if (op == OP_APPEND && loaded.size() < SNP_TABLE_DEPTH) loaded.push_back(pos);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(input logic [PDATA_W-1:0] m, input logic [PDATA_W-1:0] t,
                           input logic [PDATA_W-1:0] q);
    apb_write(REG_CLUSTER_MARGIN, m);
    apb_write(REG_RATIO_THRESHOLD, t);
    apb_write(REG_MIN_BASE_QUALITY, q);
  endtask

  task automatic noise();
    int op;
    op = $urandom_range(0, 7);
    if (op == OP_CLEAR && $urandom_range(0, 1)) op = 5;
    offer(3'(op), POS_W'($urandom_range(0, POS_MAX)), QUAL_W'($urandom_range(0, 255)));
  endtask

  // Loads a sorted table whose gaps sit around the cluster margin.
  task automatic load_table();
    int n;
    longint p, g;
    offer(OP_CLEAR, '0, '0);
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = $urandom_range(40, 60);
      default: n = $urandom_range(1, 20);
    endcase
    case ($urandom_range(0, 3))
      0: p = longint'($urandom_range(0, POS_MAX));
      1: p = longint'(POS_MAX) - longint'($urandom_range(0, 20000));
      default: p = longint'($urandom_range(0, 3000));
    endcase
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        case ($urandom_range(0, 5))
          0: g = 0;
          1: g = longint'(sb.margin);
          2: g = longint'(sb.margin) + 1;
          3: g = longint'($urandom_range(1, 50));
          4: g = longint'(sb.margin) / 2;
          default: g = longint'($urandom_range(0, 100000));
        endcase
        p = p + g;
        if (p > longint'(POS_MAX)) p = longint'(POS_MAX);
      end
      offer(OP_APPEND, POS_W'(p), QUAL_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    #50_000_000;
    $display("snp_cluster_mismatch_read_filter_core regression: fail");
    $finish;
  end

  initial begin
    int target, j, k, q;
    longint sp, mp;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    offer(OP_END, '0, '0);
    offer(OP_MISMATCH, POS_W'(5), 8'd255);
    offer(3'd5, '1, '1);
    offer(3'd7, '0, '0);
    offer(OP_START, '0, '0);
    offer(OP_END, '0, '0);
    offer(OP_APPEND, POS_W'(100), '0);
    offer(OP_APPEND, POS_W'(200), '0);
    offer(OP_APPEND, POS_W'(5000), '0);
    offer(OP_APPEND, POS_W'(5001), '0);
    offer(OP_APPEND, POS_W'(POS_MAX), '0);
    offer(OP_START, '0, '0);
    offer(OP_MISMATCH, POS_W'(100), 8'd10);
    offer(OP_MISMATCH, POS_W'(150), 8'd255);
    offer(OP_MISMATCH, POS_W'(200), 8'd9);
    offer(OP_MISMATCH, POS_W'(5000), 8'd255);
    offer(OP_END, '0, '0);
    offer(OP_START, POS_W'(5001), '0);
    offer(OP_MISMATCH, POS_W'(POS_MAX), 8'd200);
    offer(OP_END, '0, '0);
    offer(OP_START, '0, '0);
    offer(OP_START, POS_W'(POS_MAX), '0);
    offer(OP_END, '0, '0);
    offer(OP_CLEAR, '0, '0);
    offer(OP_APPEND, POS_W'(10), '0);
    offer(OP_START, POS_W'(11), '0);
    offer(OP_END, '0, '0);
    offer(OP_START, '0, '0);
    offer(OP_CLEAR, '0, '0);
    offer(OP_END, '0, '0);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: configure(0, 0, 0);
        2: configure(POS_MAX, 65536, 255);
        3: configure($urandom_range(0, 3000), $urandom_range(0, 65536), $urandom_range(0, 40));
        4: configure(1, 1, 1);
        5: configure($urandom_range(0, POS_MAX), $urandom_range(0, 65536),
                     $urandom_range(0, 255));
        default: ;
      endcase
      target = sent + 300;
      load_table();
      while (sent < target) begin
        k = $urandom_range(0, 99);
        if (k < 8) begin
          load_table();
        end else if (k >= 94) begin
          noise();
        end else begin
          if (loaded.size() > 0 && $urandom_range(0, 4) != 0) begin
            j = $urandom_range(0, loaded.size() - 1);
            sp = longint'(loaded[j]) - longint'($urandom_range(0, 2));
            if (sp < 0) sp = 0;
          end else begin
            j = loaded.size();
            sp = $urandom_range(0, 1) ? longint'($urandom_range(0, POS_MAX)) : 0;
          end
          offer(OP_START, POS_W'(sp), QUAL_W'($urandom_range(0, 255)));
          mp = sp;
          k = $urandom_range(0, 10);
          for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: begin
                j = j + $urandom_range(0, 2);
                if (j < loaded.size()) mp = longint'(loaded[j]);
                else mp = mp + longint'($urandom_range(0, 3));
              end
              6, 7: mp = mp + longint'($urandom_range(0, 2));
              8: mp = mp + longint'($urandom_range(0, 5000));
              default: noise();
            endcase
            if (mp > longint'(POS_MAX)) mp = longint'(POS_MAX);
            if ($urandom_range(0, 1)) q = $urandom_range(0, 255);
            else q = int'(sb.min_qual) + int'($urandom_range(0, 2)) - 1;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            offer(OP_MISMATCH, POS_W'(mp), QUAL_W'(q));
          end
          if ($urandom_range(0, 9) != 0)
            offer(OP_END, POS_W'($urandom_range(0, POS_MAX)), QUAL_W'($urandom_range(0, 255)));
        end
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("snp_cluster_mismatch_read_filter_core regression: pass");
    end else begin
      $display("snp_cluster_mismatch_read_filter_core regression: fail");
    end
    $finish;
  end

endmodule
